>>> sv/fss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types, constants and character helpers of the fuzzy subsequence
// scorer.
// ----------------------------------------------------------------------------
package fss_pkg;

    localparam int MaxPattern = 16;
    localparam int CharW      = 8;
    localparam int IdxW       = $clog2(MaxPattern);
    localparam int LenW       = 5;
    localparam int ScoreW     = 10;
    localparam int GainW      = 8;
    localparam int AddrW      = 5;
    localparam int DataW      = 64;
    localparam int QDepth     = 2;

    localparam logic [ScoreW-1:0] ScoreMax = ScoreW'(1023);
    localparam logic [LenW-1:0]   LenMax   = LenW'(31);
    localparam logic [LenW-1:0]   RunMax   = LenW'(31);

    localparam logic [GainW-1:0]  BonusBase     = GainW'(1);
    localparam logic [GainW-1:0]  BonusBoundary = GainW'(10);
    localparam logic [GainW-1:0]  BonusStart    = GainW'(8);
    localparam logic [GainW-1:0]  BonusCase     = GainW'(1);
    localparam logic [ScoreW-1:0] BonusShort    = ScoreW'(15);
    localparam logic [LenW:0]     ShortSlack    = (LenW + 1)'(2);

    localparam logic [CharW-1:0] ChSpace      = 8'h20;
    localparam logic [CharW-1:0] ChDash       = 8'h2D;
    localparam logic [CharW-1:0] ChUnderscore = 8'h5F;
    localparam logic [CharW-1:0] ChDot        = 8'h2E;
    localparam logic [CharW-1:0] CaseOffset   = 8'h20;

    // register byte addresses (8-byte stride)
    typedef enum logic [AddrW-1:0] {
        REG_PAT_LO  = 5'd0,
        REG_PAT_HI  = 5'd8,
        REG_PAT_LEN = 5'd16
    } reg_addr_t;

    // one classified text character
    typedef struct packed {
        logic [CharW-1:0] ch;
        logic [CharW-1:0] ch_lower;
        logic             is_upper;
        logic             is_lower;
        logic             is_sep;
        logic             last;
        logic             empty;
    } fss_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fss_qstat_t;

    function automatic logic char_is_upper(input logic [CharW-1:0] c);
        return (c inside {[8'h41 : 8'h5A]});
    endfunction

    function automatic logic char_is_lower(input logic [CharW-1:0] c);
        return (c inside {[8'h61 : 8'h7A]});
    endfunction

    function automatic logic char_is_sep(input logic [CharW-1:0] c);
        return (c inside {ChSpace, ChDash, ChUnderscore, ChDot});
    endfunction

    function automatic logic [CharW-1:0] to_lower(input logic [CharW-1:0] c);
        return char_is_upper(c) ? c + CaseOffset : c;
    endfunction

endpackage
`default_nettype wire

>>> sv/fss_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fss_in_if
// Text character channel: valid/ready with one character per transaction.
// ----------------------------------------------------------------------------
interface fss_in_if;
    logic                      valid;
    logic                      ready;
    logic [fss_pkg::CharW-1:0] text_char;
    logic                      last_char;
    logic                      empty_text;

    modport source (output valid, text_char, last_char, empty_text, input ready);
    modport sink   (input valid, text_char, last_char, empty_text, output ready);
endinterface
`default_nettype wire

>>> sv/fss_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fss_out_if
// Score result channel: valid/ready with one score per transaction.
// ----------------------------------------------------------------------------
interface fss_out_if;
    logic                       valid;
    logic                       ready;
    logic [fss_pkg::ScoreW-1:0] match_score;
    logic                       matched;

    modport source (output valid, match_score, matched, input ready);
    modport sink   (input valid, match_score, matched, output ready);
endinterface
`default_nettype wire

>>> sv/fss_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fss_front
// Accepts text characters and classifies them (case fold, letter class,
// separator) before they enter the queue.
// ----------------------------------------------------------------------------
module fss_front (
    fss_in_if.sink              in_ch,
    input  fss_pkg::fss_qstat_t qstat,
    output logic                push,
    output fss_pkg::fss_item_t  item
);

    assign in_ch.ready = !qstat.full;
    assign push        = in_ch.valid && !qstat.full;

    always_comb
    begin
        item.ch       = in_ch.text_char;
        item.ch_lower = fss_pkg::to_lower(in_ch.text_char);
        item.is_upper = fss_pkg::char_is_upper(in_ch.text_char);
        item.is_lower = fss_pkg::char_is_lower(in_ch.text_char);
        item.is_sep   = fss_pkg::char_is_sep(in_ch.text_char);
        item.last     = in_ch.last_char;
        item.empty    = in_ch.empty_text;
    end

endmodule
`default_nettype wire

>>> sv/fss_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fss_queue
// Two-entry FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
module fss_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fss_pkg::fss_item_t  push_item,
    input  logic                pop,
    output fss_pkg::fss_item_t  head_item,
    output fss_pkg::fss_qstat_t qstat
);

    localparam int PtrW = $clog2(fss_pkg::QDepth);
    localparam int CntW = $clog2(fss_pkg::QDepth + 1);

    fss_pkg::fss_item_t entry_reg [fss_pkg::QDepth];
    logic [PtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]    count_reg, count_next;
    logic               do_push, do_pop;

    assign qstat.full  = (count_reg == CntW'(fss_pkg::QDepth));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PtrW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PtrW'(1) : rd_ptr_reg;
        count_next  = count_reg + CntW'(do_push) - CntW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

>>> sv/fss_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fss_back
// Greedy subsequence matcher: per-text match state, score accumulation and
// the registered result stage.
// ----------------------------------------------------------------------------
module fss_back (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  fss_pkg::fss_item_t                      item,
    input  fss_pkg::fss_qstat_t                     qstat,
    input  logic [fss_pkg::DataW-1:0]               pattern_lo,
    input  logic [fss_pkg::DataW-1:0]               pattern_hi,
    input  logic [fss_pkg::LenW-1:0]                plen,
    output logic                                    pop,
    fss_out_if.source                               out_ch
);

    localparam int LenW   = fss_pkg::LenW;
    localparam int ScoreW = fss_pkg::ScoreW;
    localparam int GainW  = fss_pkg::GainW;
    localparam int CharW  = fss_pkg::CharW;

    logic [fss_pkg::MaxPattern-1:0][CharW-1:0] pat;

    logic [LenW-1:0]   count_reg, count_next;
    logic [LenW-1:0]   run_reg, run_next;
    logic [ScoreW-1:0] score_reg, score_next;
    logic [LenW-1:0]   len_reg, len_next;
    logic              prev_sep_reg, prev_sep_next;
    logic              prev_lower_reg, prev_lower_next;

    logic              out_valid_reg, out_valid_next;
    logic [ScoreW-1:0] out_score_reg, out_score_next;
    logic              out_matched_reg, out_matched_next;

    logic [CharW-1:0]  p_char;
    logic              active, hit, at_start, boundary, ends, out_free;
    logic [GainW-1:0]  gain;
    logic [ScoreW:0]   sum_wide, fin_wide;
    logic [ScoreW-1:0] score_upd, res_score;
    logic [LenW-1:0]   count_upd, run_upd, len_upd;
    logic              res_matched;

    assign pat = {pattern_hi, pattern_lo};

    always_comb
    begin
        p_char   = pat[count_reg[fss_pkg::IdxW-1:0]];
        active   = (count_reg < plen);
        hit      = active && (item.ch_lower == fss_pkg::to_lower(p_char));
        at_start = (len_reg == '0);
        boundary = at_start || prev_sep_reg || (prev_lower_reg && item.is_upper);

        gain = fss_pkg::BonusBase
             + (boundary ? fss_pkg::BonusBoundary : '0)
             + {1'b0, run_reg, 2'b00}
             + (at_start ? fss_pkg::BonusStart : '0)
             + ((item.ch == p_char) ? fss_pkg::BonusCase : '0);

        sum_wide = {1'b0, score_reg} + (ScoreW + 1)'(gain);

        if (hit)
        begin
            score_upd = (sum_wide > {1'b0, fss_pkg::ScoreMax}) ? fss_pkg::ScoreMax
                                                              : sum_wide[ScoreW-1:0];
            run_upd   = (run_reg == fss_pkg::RunMax) ? run_reg : run_reg + LenW'(1);
            count_upd = count_reg + LenW'(1);
        end
        else
        begin
            score_upd = score_reg;
            run_upd   = active ? '0 : run_reg;
            count_upd = count_reg;
        end
        len_upd = (len_reg == fss_pkg::LenMax) ? len_reg : len_reg + LenW'(1);

        // final score, short-text bonus when the text is at most two characters longer than the pattern
        fin_wide = {1'b0, score_upd}
                 + (({1'b0, len_upd} <= ({1'b0, plen} + fss_pkg::ShortSlack))
                    ? {1'b0, fss_pkg::BonusShort} : '0);

        if (plen == '0)
        begin
            res_score   = ScoreW'(1);
            res_matched = 1'b1;
        end
        else if (item.empty || (count_upd < plen))
        begin
            res_score   = '0;
            res_matched = 1'b0;
        end
        else
        begin
            res_score   = (fin_wide > {1'b0, fss_pkg::ScoreMax}) ? fss_pkg::ScoreMax
                                                                : fin_wide[ScoreW-1:0];
            res_matched = 1'b1;
        end

        ends     = item.empty || item.last;
        out_free = !out_valid_reg || out_ch.ready;
        pop      = !qstat.empty && (!ends || out_free);

        count_next       = count_reg;
        run_next         = run_reg;
        score_next       = score_reg;
        len_next         = len_reg;
        prev_sep_next    = prev_sep_reg;
        prev_lower_next  = prev_lower_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        out_score_next   = out_score_reg;
        out_matched_next = out_matched_reg;

        if (pop)
        begin
            if (ends)
            begin
                count_next       = '0;
                run_next         = '0;
                score_next       = '0;
                len_next         = '0;
                prev_sep_next    = 1'b0;
                prev_lower_next  = 1'b0;
                out_valid_next   = 1'b1;
                out_score_next   = res_score;
                out_matched_next = res_matched;
            end
            else
            begin
                count_next      = count_upd;
                run_next        = run_upd;
                score_next      = score_upd;
                len_next        = len_upd;
                prev_sep_next   = item.is_sep;
                prev_lower_next = item.is_lower;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            run_reg        <= '0;
            score_reg      <= '0;
            len_reg        <= '0;
            prev_sep_reg   <= 1'b0;
            prev_lower_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            run_reg        <= run_next;
            score_reg      <= score_next;
            len_reg        <= len_next;
            prev_sep_reg   <= prev_sep_next;
            prev_lower_reg <= prev_lower_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_score_reg   <= out_score_next;
        out_matched_reg <= out_matched_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.match_score = out_score_reg;
    assign out_ch.matched     = out_matched_reg;

endmodule
`default_nettype wire

>>> sv/fuzzy_subsequence_scorer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer_unit
// Streams candidate texts one character per transaction and returns one
// fuzzy subsequence score per text against a configured pattern.
// ----------------------------------------------------------------------------
// Usage:
//   - Program the pattern over APB: 0x00 chars 0..7, 0x08 chars 8..15,
//     0x10 pattern length (0 = empty, values above 16 act as 16). Writes
//     complete without wait states, pready is tied high. Reprogram only when idle.
//   - in_ch carries one text character per transaction; last_char tags the
//     final character, empty_text sends a whole empty text in one transaction.
//   - out_ch returns one transaction per text: match_score and matched.
// Timing:
//   - Throughput is one character per cycle unless a held result stalls the
//     back. The front classifies a character as it is accepted, a 2-entry
//     queue decouples it from the back, and the back updates the match state
//     once per cycle while not stalled. The final character is written into a
//     queue entry when accepted; the result register loads when it is popped.
// Reset:
//   - rst_n clears the pattern registers, the queue, the per-text state and
//     the result valid. The block is ready to accept characters out of reset.
// Backpressure:
//   - A held result stalls only the back on a text-ending character; the
//     queue absorbs one more character before in_ch.ready drops.
// ----------------------------------------------------------------------------
module fuzzy_subsequence_scorer_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fss_pkg::AddrW-1:0]    paddr,
    input  logic [fss_pkg::DataW-1:0]    pwdata,
    output logic [fss_pkg::DataW-1:0]    prdata,
    output logic                         pready,
    fss_in_if.sink                       in_ch,
    fss_out_if.source                    out_ch
);

    localparam int LenW  = fss_pkg::LenW;
    localparam int DataW = fss_pkg::DataW;

    // pattern configuration registers
    logic [DataW-1:0] pat_lo_reg, pat_lo_next;
    logic [DataW-1:0] pat_hi_reg, pat_hi_next;
    logic [LenW-1:0]  plen_reg, plen_next;
    logic [LenW-1:0]  plen_eff;
    logic             cfg_wr;

    // front/queue/back plumbing
    fss_pkg::fss_item_t  front_item, head_item;
    fss_pkg::fss_qstat_t qstat;
    logic                push, pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        pat_lo_next = pat_lo_reg;
        pat_hi_next = pat_hi_reg;
        plen_next   = plen_reg;
        if (cfg_wr)
        begin
            case (paddr)
                fss_pkg::REG_PAT_LO:  pat_lo_next = pwdata;
                fss_pkg::REG_PAT_HI:  pat_hi_next = pwdata;
                fss_pkg::REG_PAT_LEN: plen_next   = pwdata[LenW-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            fss_pkg::REG_PAT_LO:  prdata = pat_lo_reg;
            fss_pkg::REG_PAT_HI:  prdata = pat_hi_reg;
            fss_pkg::REG_PAT_LEN: prdata = DataW'(plen_reg);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            plen_reg   <= '0;
        end
        else
        begin
            pat_lo_reg <= pat_lo_next;
            pat_hi_reg <= pat_hi_next;
            plen_reg   <= plen_next;
        end
    end

    // lengths above the pattern capacity clamp to it
    assign plen_eff = (plen_reg > LenW'(fss_pkg::MaxPattern)) ? LenW'(fss_pkg::MaxPattern)
                                                              : plen_reg;

    fss_front u_front (
        .in_ch (in_ch),
        .qstat (qstat),
        .push  (push),
        .item  (front_item)
    );

    fss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    fss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (head_item),
        .qstat      (qstat),
        .pattern_lo (pat_lo_reg),
        .pattern_hi (pat_hi_reg),
        .plen       (plen_eff),
        .pop        (pop),
        .out_ch     (out_ch)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // an unmatched text always scores zero
    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.matched) |-> (out_ch.match_score == '0))
        else $error("unmatched result with nonzero score");

    // a matched text always scores at least one
    a_match_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.matched) |-> (out_ch.match_score != '0))
        else $error("matched result with zero score");

    // the back never consumes from an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

    // a full queue holds off the input channel
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full |-> !in_ch.ready)
        else $error("input ready while queue full");

endmodule
`default_nettype wire

>>> tb/fss_score_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_score_checker
// Passive scoreboard for the fuzzy subsequence scorer. Follows APB pattern
// writes, predicts one score per text from the accepted characters and
// compares every returned score with the oldest prediction.
// ----------------------------------------------------------------------------
module fss_score_checker
    import fss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [AddrW-1:0]   paddr,
    input  logic [DataW-1:0]   pwdata,
    fss_in_if                  in_mon,
    fss_out_if                 out_mon,
    output int                 mismatches,
    output int                 scores_pending
);

    typedef struct packed {
        logic [ScoreW-1:0] score;
        logic              matched;
    } score_rec_t;

    // shadow of the pattern registers
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [4:0]  pat_len;

    // per-text match state
    logic [LenW-1:0]   matched_cnt;
    logic [LenW-1:0]   run_len;
    logic [ScoreW-1:0] score_acc;
    logic [CharW-1:0]  prev_char;
    logic [LenW-1:0]   text_len;

    score_rec_t expected_scores [$];

    function automatic logic [CharW-1:0] fold_case(input logic [CharW-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic void clear_text();
        matched_cnt = '0;
        run_len     = '0;
        score_acc   = '0;
        prev_char   = '0;
        text_len    = '0;
    endfunction

    // Advances the match state by one transaction; returns 1 when it ends a text.
    function automatic bit score_char(input logic [CharW-1:0] c, input logic last,
                                      input logic empty, output score_rec_t rec);
        int               plen;
        int               gain;
        int               total;
        logic [3:0]       idx;
        logic [CharW-1:0] pc;
        logic             at_start;
        logic             boundary;
        plen = (pat_len > MaxPattern) ? MaxPattern : int'(pat_len);
        rec  = '0;
        if (empty) begin
            // empty text drops whatever was streamed so far
            clear_text();
            rec.score   = (plen == 0) ? ScoreW'(1) : '0;
            rec.matched = (plen == 0);
            return 1'b1;
        end
        if (matched_cnt < plen) begin
            idx = matched_cnt[3:0];
            pc  = idx[3] ? pat_hi[8*idx[2:0] +: 8] : pat_lo[8*idx[2:0] +: 8];
            if (fold_case(c) == fold_case(pc)) begin
                at_start = (text_len == 0);
                boundary = at_start || prev_char == ChSpace || prev_char == ChDash ||
                           prev_char == ChUnderscore || prev_char == ChDot ||
                           (prev_char >= 8'h61 && prev_char <= 8'h7A &&
                            c >= 8'h41 && c <= 8'h5A);
                gain = 1 + (boundary ? 10 : 0) + 4 * int'(run_len) +
                       (at_start ? 8 : 0) + ((c == pc) ? 1 : 0);
                total = int'(score_acc) + gain;
                score_acc = (total > int'(ScoreMax)) ? ScoreMax : ScoreW'(total);
                if (run_len < RunMax)
                    run_len = run_len + 1'b1;
                matched_cnt = matched_cnt + 1'b1;
            end else begin
                run_len = '0;
            end
        end
        prev_char = c;
        if (text_len < LenMax)
            text_len = text_len + 1'b1;
        if (!last)
            return 1'b0;
        if (plen == 0) begin
            rec.score   = ScoreW'(1);
            rec.matched = 1'b1;
        end else if (matched_cnt >= plen) begin
            total = int'(score_acc) + ((int'(text_len) <= plen + 2) ? 15 : 0);
            rec.score   = (total > int'(ScoreMax)) ? ScoreMax : ScoreW'(total);
            rec.matched = 1'b1;
        end
        clear_text();
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        score_rec_t got;
        score_rec_t want;
        if (!rst_n) begin
            pat_lo  = '0;
            pat_hi  = '0;
            pat_len = '0;
            clear_text();
            expected_scores.delete();
            scores_pending = 0;
            mismatches     = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    REG_PAT_LO:  pat_lo  = pwdata;
                    REG_PAT_HI:  pat_hi  = pwdata;
                    REG_PAT_LEN: pat_len = pwdata[4:0];
                    default: ;
                endcase
            end
            if (out_mon.valid && out_mon.ready) begin
                got.score   = out_mon.match_score;
                got.matched = out_mon.matched;
                if (expected_scores.size() == 0) begin
                    $error("unexpected score transaction: match_score %0d matched %0d",
                           got.score, got.matched);
                    mismatches++;
                end else begin
                    want = expected_scores.pop_front();
                    if (got.score !== want.score) begin
                        $error("match_score mismatch: expected %0d, actual %0d",
                               want.score, got.score);
                        mismatches++;
                    end
                    if (got.matched !== want.matched) begin
                        $error("matched mismatch: expected %0d, actual %0d",
                               want.matched, got.matched);
                        mismatches++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready) begin
                if (score_char(in_mon.text_char, in_mon.last_char, in_mon.empty_text, want))
                    expected_scores.push_back(want);
            end
            scores_pending = expected_scores.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for fuzzy_subsequence_scorer_unit. A directed set of
// texts covers boundaries, case rules and empty inputs, then randomized
// phases reprogram the pattern over APB and stream mostly matching texts
// with random gaps and output backpressure. Scoring is checked by
// fss_score_checker.
// ----------------------------------------------------------------------------
module testbench;
    import fss_pkg::*;

    localparam int NumItems     = 1500;
    localparam int IdleLimit    = 1000;  // cycles with no transaction at all
    localparam int SettleCycles = 6;     // queue plus result register, with margin

    logic             clk;
    logic             rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [AddrW-1:0] paddr;
    logic [DataW-1:0] pwdata;
    logic [DataW-1:0] prdata;
    logic             pready;

    fss_in_if  in_ch ();
    fss_out_if out_ch ();

    int mismatches;
    int scores_pending;

    // gap knobs, changed per phase so some phases run back to back
    bit sender_idle;
    bit receiver_idle;
    int items_sent;
    int idle_cycles;

    // local copy of the active pattern, used to build matching texts
    logic [CharW-1:0] pat_bytes [16];
    int               pat_used;

    fuzzy_subsequence_scorer_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    fss_score_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .in_mon         (in_ch),
        .out_mon        (out_ch),
        .mismatches     (mismatches),
        .scores_pending (scores_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Mostly short gaps, occasionally a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Filler text byte: letters of both cases, separators and raw bytes.
    function automatic logic [CharW-1:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return CharW'($urandom_range(8'h61, 8'h7A));
        else if (r < 60)
            return CharW'($urandom_range(8'h41, 8'h5A));
        else if (r < 75)
        begin
            case ($urandom_range(0, 3))
                0: return ChSpace;
                1: return ChDash;
                2: return ChUnderscore;
                default: return ChDot;
            endcase
        end
        return CharW'($urandom_range(0, 255));
    endfunction

    function automatic logic [CharW-1:0] flip_case(input logic [CharW-1:0] c);
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
            return c ^ 8'h20;
        return c;
    endfunction

    // One APB write: setup phase, then access phase until pready.
    task automatic apb_write(input reg_addr_t addr, input logic [DataW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Sends one character transaction; valid stays high for a following
    // item unless a gap is drawn.
    task automatic send_item(input logic [CharW-1:0] c, input logic last,
                             input logic empty);
        int gap;
        gap = sender_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid      <= 1'b1;
        in_ch.text_char  <= c;
        in_ch.last_char  <= last;
        in_ch.empty_text <= empty;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic send_text(input string s, input bit end_text);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], end_text && (i == s.len() - 1), 1'b0);
    endtask

    // Stops the sender and lets every score come back before the next
    // register write; extra cycles cover characters that make no result.
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (scores_pending != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    // Picks and programs a new pattern; extremes of length and data included.
    task automatic program_pattern();
        logic [DataW-1:0] lo;
        logic [DataW-1:0] hi;
        logic [4:0]       len_reg;
        int               r;
        for (int i = 0; i < 16; i++)
        begin
            if ($urandom_range(0, 3) != 0)
                pat_bytes[i] = ($urandom_range(0, 1) != 0) ?
                    CharW'($urandom_range(8'h61, 8'h7A)) :
                    CharW'($urandom_range(8'h41, 8'h5A));
            else
                pat_bytes[i] = CharW'($urandom_range(0, 255));
        end
        r = $urandom_range(0, 19);
        if (r == 0)
            foreach (pat_bytes[i]) pat_bytes[i] = 8'hFF;
        else if (r == 1)
            foreach (pat_bytes[i]) pat_bytes[i] = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            lo[8*i +: 8] = pat_bytes[i];
            hi[8*i +: 8] = pat_bytes[i+8];
        end
        r = $urandom_range(0, 99);
        if (r < 10)
            len_reg = 5'd0;
        else if (r < 20)
            len_reg = 5'd16;
        else if (r < 30)
            len_reg = 5'($urandom_range(17, 31));  // clamps to 16 in the block
        else if (r < 40)
            len_reg = 5'd1;
        else
            len_reg = 5'($urandom_range(2, 8));
        pat_used = (len_reg > MaxPattern) ? MaxPattern : int'(len_reg);
        apb_write(REG_PAT_LO, lo);
        apb_write(REG_PAT_HI, hi);
        // upper bits of the length register write ignored garbage
        apb_write(REG_PAT_LEN, {$urandom, $urandom} & ~64'h1F | 64'(len_reg));
    endtask

    // Output backpressure: random stalls while receiver_idle is set.
    initial
    begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (receiver_idle && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    // Watchdog: any handshake or APB access counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        logic [CharW-1:0] txt [$];
        int               kind;
        int               phase_items;
        int               phase_goal;

        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_ch.valid      = 1'b0;
        in_ch.text_char  = '0;
        in_ch.last_char  = 1'b0;
        in_ch.empty_text = 1'b0;
        sender_idle      = 1'b0;
        receiver_idle    = 1'b0;
        items_sent       = 0;
        idle_cycles      = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed: pattern "aBcD" ----
        apb_write(REG_PAT_LO, 64'h0000_0000_4463_4261);
        apb_write(REG_PAT_HI, 64'h0);
        apb_write(REG_PAT_LEN, 64'd4);
        send_text("aBcD", 1'b1);          // exact case, run, start bonus, short text
        send_text("Ab-c_D", 1'b1);        // case mismatch, dash and underscore boundaries
        send_text("z.a bcDq", 1'b1);      // dot and space boundaries, trailing byte, long
        send_item(8'hFF, 1'b0, 1'b0);     // extreme bytes, no match
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);     // empty text
        send_text("ab", 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);     // empty text without last drops partial text
        // shorten the pattern in the middle of a text
        send_text("ab", 1'b0);
        settle();
        apb_write(REG_PAT_LEN, 64'd1);
        send_text("x", 1'b1);
        // empty pattern
        settle();
        apb_write(REG_PAT_LEN, 64'd0);
        send_text("q", 1'b1);
        send_item(8'h41, 1'b1, 1'b1);

        // ---- random phases ----
        while (items_sent < NumItems)
        begin
            settle();
            program_pattern();
            sender_idle   = ($urandom_range(0, 3) != 0);
            receiver_idle = ($urandom_range(0, 3) != 0);
            phase_items   = 0;
            phase_goal    = $urandom_range(40, 150);
            while (phase_items < phase_goal)
            begin
                txt.delete();
                kind = $urandom_range(0, 99);
                if (kind < 8)
                begin
                    // empty text, sometimes cutting off a partial text
                    if ($urandom_range(0, 1) != 0)
                        repeat ($urandom_range(1, 4)) send_item(random_char(), 1'b0, 1'b0);
                    send_item(CharW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'b1);
                    phase_items++;
                    continue;
                end
                else if (kind < 75)
                begin
                    // pattern embedded with fillers, case flips and rare drops
                    for (int k = 0; k < pat_used; k++)
                    begin
                        repeat ($urandom_range(0, 2)) txt.push_back(random_char());
                        if ($urandom_range(0, 19) != 0)
                            txt.push_back(($urandom_range(0, 1) != 0) ?
                                          flip_case(pat_bytes[k]) : pat_bytes[k]);
                    end
                    repeat ($urandom_range(0, 3)) txt.push_back(random_char());
                    if ($urandom_range(0, 19) == 0)
                        repeat (32) txt.push_back(random_char());  // saturates length
                end
                else
                begin
                    repeat ($urandom_range(1, 12)) txt.push_back(random_char());
                end
                if (txt.size() == 0)
                    txt.push_back(random_char());
                foreach (txt[i])
                    send_item(txt[i], i == txt.size() - 1, 1'b0);
                phase_items += txt.size();
            end
        end

        // ---- drain and verdict ----
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (scores_pending != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
        if (mismatches == 0 && scores_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
